[rtl/core/ils_pkg.sv]
// Shared field widths, command and status codes, and the cell operation type.
`default_nettype none

package ils_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 6;
  localparam int LCOUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

endpackage

`default_nettype wire

[rtl/core/ils_cell.sv]
// One list slot: holds a word and loads it from the key or a neighbor.
`default_nettype none

module ils_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  ils_pkg::cell_op_t     op_i,
  input  logic [CNT_W-1:0]      pos_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [WORD_WIDTH-1:0] key_i,
  input  logic [WORD_WIDTH-1:0] left_i,
  input  logic [WORD_WIDTH-1:0] right_i,
  output logic [WORD_WIDTH-1:0] word_o
);
  import ils_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(INDEX + 1);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (op_i)
      CELL_PUSH: begin
        if (count_i == MY_IDX) word_nxt = key_i;
      end
      CELL_INSERT: begin
        if (MY_IDX == pos_i) begin
          word_nxt = key_i;
        end else if (MY_IDX > pos_i && MY_IDX <= count_i) begin
          word_nxt = left_i;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= pos_i && NEXT_IDX < count_i) word_nxt = right_i;
      end
      // The whole row turns one place toward slot zero.
      CELL_ROTATE: word_nxt = right_i;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

`default_nettype wire

[rtl/core/ils_ctrl.sv]
// Command sequencer: count, range checks, scan of slot zero, result queue.
`default_nettype none

module ils_ctrl #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ils_pkg::CMD_W-1:0]     in_command,
  input  logic [ils_pkg::POS_W-1:0]     in_position,
  input  logic signed [ils_pkg::DATA_W-1:0] in_data_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ils_pkg::STATUS_W-1:0]  out_status,
  output logic signed [ils_pkg::DATA_W-1:0] out_read_word,
  output logic                          out_found,
  output logic [ils_pkg::FPOS_W-1:0]    out_found_position,
  output logic [ils_pkg::LCOUNT_W-1:0]  out_live_count,
  output ils_pkg::cell_op_t             cell_op,
  output logic [CNT_W-1:0]              cell_pos,
  output logic [CNT_W-1:0]              cell_count,
  output logic [WORD_WIDTH-1:0]         cell_key,
  input  logic [WORD_WIDTH-1:0]         head_word
);
  import ils_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_word;
    logic                found;
    logic [FPOS_W-1:0]   fpos;
    logic [LCOUNT_W-1:0] live_count;
  } res_t;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic                  find_r, find_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic                  hit_r, hit_nxt;
  logic [FPOS_W-1:0]     fpos_r, fpos_nxt;
  logic [DATA_W-1:0]     rd_r, rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r, out_res_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  res_t                  pend_res_r, pend_res_nxt;

  logic                  accept;
  logic                  new_valid;
  res_t                  new_res;
  logic [CMP_W-1:0]      pos_cmp;
  logic [CMP_W-1:0]      cnt_cmp;
  logic                  full;
  logic [WORD_WIDTH-1:0] in_key;

  assign in_stall = (state_r != S_IDLE) || pend_valid_r;
  assign accept   = in_valid && !in_stall;
  assign pos_cmp  = CMP_W'(in_position);
  assign cnt_cmp  = CMP_W'(count_r);
  assign full     = (count_r == FULL_CNT);
  assign in_key   = WORD_WIDTH'($unsigned(in_data_word));

  assign cell_pos   = CNT_W'(in_position);
  assign cell_count = count_r;
  assign cell_key   = in_key;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    find_nxt  = find_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    hit_nxt   = hit_r;
    fpos_nxt  = fpos_r;
    rd_nxt    = rd_r;
    cell_op   = CELL_HOLD;
    new_valid = 1'b0;
    new_res   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_valid = 1'b1;
          unique case (in_command) inside
            CMD_PUSH: begin
              if (full) begin
                new_res.status = ST_FULL;
              end else begin
                cell_op   = CELL_PUSH;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (count_r != '0) count_nxt = count_r - CNT_W'(1);
            end
            CMD_INSERT: begin
              if (pos_cmp > cnt_cmp) begin
                new_res.status = ST_RANGE;
              end else if (full) begin
                new_res.status = ST_FULL;
              end else begin
                cell_op   = CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (pos_cmp >= cnt_cmp) begin
                new_res.status = ST_RANGE;
              end else begin
                cell_op   = CELL_DELETE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_READ, CMD_FIND: begin
              if (in_command == CMD_READ && pos_cmp >= cnt_cmp) begin
                new_res.status = ST_RANGE;
              end else begin
                // Result comes when the row has turned once past slot zero.
                new_valid = 1'b0;
                state_nxt = S_SCAN;
                find_nxt  = (in_command == CMD_FIND);
                pos_nxt   = CNT_W'(in_position);
                key_nxt   = in_key;
                step_nxt  = '0;
                hit_nxt   = 1'b0;
                fpos_nxt  = '0;
                rd_nxt    = '0;
              end
            end
            default: begin
              new_res.status = ST_OK;
            end
          endcase
          new_res.live_count = LCOUNT_W'(count_nxt);
        end
      end
      S_SCAN: begin
        // Slot zero holds the word of list index step_r during this cycle.
        cell_op  = CELL_ROTATE;
        step_nxt = step_r + IDX_W'(1);
        if (find_r) begin
          if (!hit_r && CNT_W'(step_r) < count_r && head_word == key_r) begin
            hit_nxt  = 1'b1;
            fpos_nxt = FPOS_W'(step_r);
          end
        end else if (CNT_W'(step_r) == pos_r) begin
          rd_nxt = DATA_W'(head_word);
        end
        if (step_r == LAST_STEP) begin
          state_nxt          = S_IDLE;
          new_valid          = 1'b1;
          new_res.status     = ST_OK;
          new_res.read_word  = rd_nxt;
          new_res.found      = hit_nxt;
          new_res.fpos       = fpos_nxt;
          new_res.live_count = LCOUNT_W'(count_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Two-slot result queue so a finished beat is never lost; new commands stall while the second slot is full.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    if (!out_valid_r || !out_stall) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = new_valid;
        out_res_nxt   = new_res;
      end
    end else if (new_valid) begin
      pend_valid_nxt = 1'b1;
      pend_res_nxt   = new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      step_r       <= '0;
      find_r       <= 1'b0;
      pos_r        <= '0;
      key_r        <= '0;
      hit_r        <= 1'b0;
      fpos_r       <= '0;
      rd_r         <= '0;
      out_valid_r  <= 1'b0;
      out_res_r    <= '0;
      pend_valid_r <= 1'b0;
      pend_res_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      find_r       <= find_nxt;
      pos_r        <= pos_nxt;
      key_r        <= key_nxt;
      hit_r        <= hit_nxt;
      fpos_r       <= fpos_nxt;
      rd_r         <= rd_nxt;
      out_valid_r  <= out_valid_nxt;
      out_res_r    <= out_res_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_res_r   <= pend_res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_read_word      = out_res_r.read_word;
  assign out_found          = out_res_r.found;
  assign out_found_position = out_res_r.fpos;
  assign out_live_count     = out_res_r.live_count;

endmodule

`default_nettype wire

[rtl/core/indexed_list_store.sv]
// Top level of the indexed list store: sequencer and the row of list slots.
`default_nettype none

// An ordered list of up to DEPTH words kept in a row of slots, slot i holding
// list index i. Insert and delete shift slots from their neighbors at once,
// push loads one slot and pop only lowers the count; their result beat, like
// any range or full refusal, goes straight from the taken command beat into
// the result queue. Read and find turn the whole row once past slot zero,
// one place per cycle, which restores the order; their result is queued when
// the turn ends. One command is in work at a time; in_stall stays high during
// a turn and while a second result waits behind an unread one. Words are not
// cleared at reset; only slots below the live count are ever looked at.

module indexed_list_store #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ils_pkg::CMD_W-1:0]     in_command,
  input  logic [ils_pkg::POS_W-1:0]     in_position,
  input  logic signed [ils_pkg::DATA_W-1:0] in_data_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ils_pkg::STATUS_W-1:0]  out_status,
  output logic signed [ils_pkg::DATA_W-1:0] out_read_word,
  output logic                          out_found,
  output logic [ils_pkg::FPOS_W-1:0]    out_found_position,
  output logic [ils_pkg::LCOUNT_W-1:0]  out_live_count
);
  import ils_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_op_t              cell_op;
  logic [CNT_W-1:0]      cell_pos;
  logic [CNT_W-1:0]      cell_count;
  logic [WORD_WIDTH-1:0] cell_key;
  logic [WORD_WIDTH-1:0] word_w [DEPTH];

  ils_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_data_word       (in_data_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_word      (out_read_word),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_live_count     (out_live_count),
    .cell_op            (cell_op),
    .cell_pos           (cell_pos),
    .cell_count         (cell_count),
    .cell_key           (cell_key),
    .head_word          (word_w[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // The last slot takes from slot zero so a turn closes the ring.
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == DEPTH - 1) ? 0 : i + 1;

    ils_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .op_i    (cell_op),
      .pos_i   (cell_pos),
      .count_i (cell_count),
      .key_i   (cell_key),
      .left_i  (word_w[LEFT]),
      .right_i (word_w[RIGHT]),
      .word_o  (word_w[i])
    );
  end

endmodule

`default_nettype wire

[tb/indexed_list_store_test.sv]
// Self-checking testbench for the indexed list store: directed and random command traffic against a scoreboard.
`timescale 1ns / 100ps

module indexed_list_store_test;
  import ils_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 850;

  // Command codes the block leaves undefined; they must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef enum int {
    TRAFFIC_GROW,
    TRAFFIC_CHURN,
    TRAFFIC_SHRINK
  } traffic_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_word;
    logic                     found;
    logic [FPOS_W-1:0]        found_position;
    logic [LCOUNT_W-1:0]      live_count;
  } list_reply_t;

  class list_scoreboard;
    logic [DATA_W-1:0] model_words [LIST_DEPTH];
    int unsigned       model_count;
    list_reply_t       pending_replies [$];
    int unsigned       failures;

    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] word);
      list_reply_t exp;
      int unsigned i;
      exp = '0;
      case (cmd)
        CMD_PUSH: begin
          if (model_count >= LIST_DEPTH) begin
            exp.status = ST_FULL;
          end else begin
            model_words[model_count] = word;
            model_count++;
          end
        end
        CMD_POP: begin
          if (model_count > 0) model_count--;
        end
        CMD_INSERT: begin
          // The range check wins over the full check.
          if (pos > model_count) begin
            exp.status = ST_RANGE;
          end else if (model_count >= LIST_DEPTH) begin
            exp.status = ST_FULL;
          end else begin
            for (i = model_count; i > pos; i--) model_words[i] = model_words[i-1];
            model_words[pos] = word;
            model_count++;
          end
        end
        CMD_DELETE: begin
          if (pos >= model_count) begin
            exp.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < model_count; i++) model_words[i] = model_words[i+1];
            model_count--;
          end
        end
        CMD_READ: begin
          if (pos >= model_count) exp.status = ST_RANGE;
          else exp.read_word = model_words[pos];
        end
        CMD_FIND: begin
          for (i = 0; i < model_count; i++) begin
            if (model_words[i] == word) begin
              exp.found = 1'b1;
              exp.found_position = FPOS_W'(i);
              break;
            end
          end
        end
        default: ;
      endcase
      exp.live_count = LCOUNT_W'(model_count);
      pending_replies.push_back(exp);
    endfunction

    function void check_reply(list_reply_t got);
      list_reply_t exp;
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result beat: status=%0d count=%0d",
                                     got.status, got.live_count);
        return;
      end
      exp = pending_replies.pop_front();
      if (got.status !== exp.status || got.read_word !== exp.read_word ||
          got.found !== exp.found || got.found_position !== exp.found_position ||
          got.live_count !== exp.live_count) begin
        failures++;
        if (failures <= 10) begin
          $display("result mismatch: expected status=%0d word=%h found=%0d pos=%0d count=%0d",
                   exp.status, exp.read_word, exp.found, exp.found_position,
                   exp.live_count);
          $display("                 actual   status=%0d word=%h found=%0d pos=%0d count=%0d",
                   got.status, got.read_word, got.found, got.found_position,
                   got.live_count);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = CMD_PUSH;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_data_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_read_word;
  logic                     out_found;
  logic [FPOS_W-1:0]        out_found_position;
  logic [LCOUNT_W-1:0]      out_live_count;

  int                       sender_idle_pct = 14;
  int                       receiver_idle_pct = 60;
  list_scoreboard           sb = new();
  list_reply_t              seen_reply;

  indexed_list_store #(
    .DEPTH(LIST_DEPTH),
    .WORD_WIDTH(DATA_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_position(in_position),
    .in_data_word(in_data_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_word(out_read_word),
    .out_found(out_found),
    .out_found_position(out_found_position),
    .out_live_count(out_live_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen_reply.status         = out_status;
      seen_reply.read_word      = out_read_word;
      seen_reply.found          = out_found;
      seen_reply.found_position = out_found_position;
      seen_reply.live_count     = out_live_count;
      sb.check_reply(seen_reply);
    end
  end

  // Entered and left at a falling edge; holds the beat until it is taken.
  task automatic drive_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_position  <= pos;
    in_data_word <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(cmd, pos, word);
    @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_opcode(traffic_t mode);
    int cuts [7];
    int r;
    case (mode)
      TRAFFIC_GROW:   cuts = '{45, 80, 83, 86, 92, 98, 100};
      TRAFFIC_SHRINK: cuts = '{5, 10, 45, 80, 88, 98, 100};
      default:        cuts = '{20, 40, 55, 70, 82, 96, 100};
    endcase
    r = $urandom_range(99);
    if (r < cuts[0]) return CMD_PUSH;
    if (r < cuts[1]) return CMD_INSERT;
    if (r < cuts[2]) return CMD_POP;
    if (r < cuts[3]) return CMD_DELETE;
    if (r < cuts[4]) return CMD_READ;
    if (r < cuts[5]) return CMD_FIND;
    return $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
  endfunction

  // Mostly legal indexes, with a share at the count itself and beyond it.
  function automatic logic [POS_W-1:0] pick_position(logic [CMD_W-1:0] cmd);
    int r;
    int live;
    r = $urandom_range(9);
    live = sb.model_count;
    case (cmd)
      CMD_INSERT: begin
        if (r == 0) return POS_W'($urandom_range(127));
        if (r == 1) return POS_W'(live);
        if (r == 2) return POS_W'((live < 127) ? live + 1 : 127);
        return POS_W'($urandom_range(live));
      end
      CMD_DELETE, CMD_READ: begin
        if (live == 0 || r == 0) return POS_W'($urandom_range(127));
        if (r == 1) return POS_W'(live);
        return POS_W'($urandom_range(live - 1));
      end
      default: return POS_W'($urandom_range(127));
    endcase
  endfunction

  // A small pool of values makes duplicates, so find meets repeated words.
  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r <= 4) return $urandom_range(7);
    return $urandom;
  endfunction

  initial begin
    int                issued;
    int                phase;
    int                run_len;
    int                k;
    traffic_t          mode;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list corner cases first.
    drive_command(CMD_POP, 7'd0, 32'h0);
    drive_command(CMD_READ, 7'd0, 32'h0);
    drive_command(CMD_DELETE, 7'd0, 32'h0);
    drive_command(CMD_INSERT, 7'd1, 32'h1111_1111);
    drive_command(CMD_FIND, 7'd0, 32'h0);
    // Insert at the count behaves as a push.
    drive_command(CMD_INSERT, 7'd0, 32'h8000_0000);
    drive_command(CMD_PUSH, 7'd127, 32'h7fff_ffff);
    drive_command(CMD_PUSH, 7'd0, 32'hffff_ffff);
    drive_command(CMD_INSERT, 7'd1, 32'h0000_0000);
    drive_command(CMD_PUSH, 7'd0, 32'h7fff_ffff);
    drive_command(CMD_INSERT, 7'd127, 32'h2222_2222);
    drive_command(CMD_READ, 7'd0, 32'h0);
    drive_command(CMD_READ, 7'd3, 32'h0);
    drive_command(CMD_READ, 7'd5, 32'h0);
    drive_command(CMD_FIND, 7'd0, 32'h7fff_ffff);
    drive_command(CMD_FIND, 7'd0, 32'h1234_5678);
    drive_command(CMD_DELETE, 7'd1, 32'h0);
    drive_command(CMD_DELETE, 7'd64, 32'h0);
    drive_command(CMD_UNUSED_LO, 7'd127, 32'hffff_ffff);
    drive_command(CMD_UNUSED_HI, 7'd3, 32'h8000_0000);
    drive_command(CMD_INSERT, 7'd4, 32'h5555_aaaa);
    drive_command(CMD_READ, 7'd127, 32'h0);
    drive_command(CMD_POP, 7'd0, 32'h0);
    drive_command(CMD_DELETE, 7'd0, 32'h0);
    drive_command(CMD_FIND, 7'd0, 32'h0000_0000);

    // Phases of growth, churn and shrinking, so the list fills and empties.
    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      mode = traffic_t'(phase % 3);
      run_len = (mode == TRAFFIC_CHURN) ? $urandom_range(90, 50) : $urandom_range(130, 90);
      for (k = 0; k < run_len && issued < RANDOM_ITEMS; k++) begin
        if (issued < RANDOM_ITEMS / 3) begin
          sender_idle_pct = 14;
          receiver_idle_pct = 60;
        end else if (issued < 2 * RANDOM_ITEMS / 3) begin
          sender_idle_pct = 60;
          receiver_idle_pct = 14;
        end else begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
        cmd = pick_opcode(mode);
        pos = pick_position(cmd);
        word = pick_word();
        if (cmd == CMD_FIND && sb.model_count > 0 && $urandom_range(1) == 1)
          word = sb.model_words[$urandom_range(sb.model_count - 1)];
        drive_command(cmd, pos, word);
        issued++;
      end
      phase++;
    end
    in_valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ils_pkg.sv
rtl/core/ils_cell.sv
rtl/core/ils_ctrl.sv
rtl/core/indexed_list_store.sv
tb/indexed_list_store_test.sv
